>>> rtl/core/rpet_pkg.sv
// Shared types, constants and codes of the ranked-pairs election tally.
// No dependencies; used by the tally store and the top level.
package rpet_pkg;

    localparam int MAX_CAND   = 8;
    localparam int CAND_W     = 3;
    localparam int CNT_W      = CAND_W + 1;
    localparam int TALLY_W    = 16;
    localparam int TALLY_AW   = 2 * CAND_W;
    localparam int TALLY_D    = MAX_CAND * MAX_CAND;
    localparam int PAIR_SLOTS = MAX_CAND * (MAX_CAND - 1) / 2;
    localparam int PAIR_W     = 5;

    localparam logic OP_BALLOT = 1'b0;
    localparam logic OP_CLOSE  = 1'b1;
    localparam logic KIND_WIN  = 1'b0;
    localparam logic KIND_ERR  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REC_LDA,
        S_REC_RD,
        S_REC_WR,
        S_BLD_RD1,
        S_BLD_RD2,
        S_BLD_CMP,
        S_SRT_LDI,
        S_SRT_CAP,
        S_SRT_RDJ,
        S_SRT_CMP,
        S_SRT_WRI,
        S_LCK_RD,
        S_LCK_CAP,
        S_LCK_GROW,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [TALLY_AW-1:0] rd_addr;
        logic                wr_en;
        logic [TALLY_AW-1:0] wr_addr;
        logic [TALLY_W-1:0]  wr_data;
        logic                clr;
    } t_tally_req;

    typedef struct packed {
        logic [CAND_W-1:0]  win;
        logic [CAND_W-1:0]  lose;
        logic [TALLY_W-1:0] score;
    } t_pair;

endpackage

>>> rtl/core/rpet_tally_store.sv
// Tally matrix store: one read port with registered data, one write port,
// and per-entry valid bits so that one clear request empties the whole matrix. Uses rpet_pkg.
module rpet_tally_store (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rpet_pkg::t_tally_req         i_req,
    output logic [rpet_pkg::TALLY_W-1:0] o_rd_data
);
    import rpet_pkg::*;

    logic [TALLY_W-1:0] r_mem [TALLY_D];
    logic [TALLY_D-1:0] r_vld;
    logic [TALLY_W-1:0] r_rd_data;
    logic               r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            r_rd_hit <= r_vld[i_req.rd_addr];
            if (i_req.clr) begin
                r_vld <= '0;
            end else if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
        end
    end

    // unwritten entries read as zero
    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

>>> rtl/core/ranked_pairs_election_tally_top.sv
// Ranked-pairs election tally, top level: sequencer, pair list, lock graph.
// Depends on rpet_pkg and rpet_tally_store.
//
// Input channel (i_in_valid / o_in_stall) carries one rank entry or a close.
// Output channel (o_out_valid / i_out_stall) carries winner or error reports.
// A transaction moves when valid is high and stall is low at a clock edge.
// i_cfg_we / i_cfg_data write the candidate count n and drop a partial ballot.
//
// The entry that completes a ballot starts a tally update of n(n-1)/2
// read-modify-write steps (a read, then a write) plus one row load for
// each of the first n-1 ranks, all through the tally store. An
// out-of-range entry gives one error result, valid on the output from
// the cycle after acceptance.
// A close builds the pair list from each candidate pair with no tie, sorts
// it by score with a swap sort over the P pairs (P(P-1)/2 compares), locks
// each pair unless its winner is reachable from its loser (one reach step
// per cycle), then reports each candidate that no locked pair enters.
// The input stalls while any of this runs, and while a result waits stalled.
// A stalled output holds its result and the sequencer waits for it.
// Reset (synchronous, active low) clears tallies, locks and the ballot
// position; the count register returns to eight.
module ranked_pairs_election_tally_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_operation,
    input  logic [rpet_pkg::CAND_W-1:0] i_candidate_index,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_result_kind,
    output logic [rpet_pkg::CAND_W-1:0] o_winner_index,
    output logic                        o_last_result,
    input  logic                        i_cfg_we,
    input  logic [rpet_pkg::CNT_W-1:0]  i_cfg_data
);
    import rpet_pkg::*;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cand_total;
    logic [CAND_W-1:0]   r_rank, n_rank;
    logic [CAND_W-1:0]   r_buf [MAX_CAND];
    logic [CAND_W-1:0]   r_ri, n_ri, r_rj, n_rj, r_a, n_a;
    logic [TALLY_W-1:0]  r_sa, n_sa;
    logic [PAIR_W-1:0]   r_pair_total, n_pair_total;
    logic [PAIR_W-1:0]   r_pi, n_pi, r_pj, n_pj;
    t_pair               r_cur, n_cur;
    logic [CAND_W-1:0]   r_w, n_w, r_l, n_l, r_ec, n_ec;
    logic [MAX_CAND-1:0] r_reach, n_reach;
    logic [MAX_CAND-1:0] r_lock [MAX_CAND];
    logic [MAX_CAND-1:0] n_lock [MAX_CAND];
    logic                r_out_valid, n_out_valid;
    logic                r_kind, n_kind, r_last, n_last;
    logic [CAND_W-1:0]   r_win, n_win;

    t_pair               r_pair_mem [PAIR_SLOTS];
    t_pair               r_pair_rd;
    logic                pm_we;
    logic [PAIR_W-1:0]   pm_waddr, pm_raddr;
    t_pair               pm_wdata;

    t_tally_req          tq;
    logic [TALLY_W-1:0]  tv;
    logic [CNT_W-1:0]    eff_n;
    logic [CAND_W-1:0]   buf_ra, buf_rd;
    logic                out_free, in_acc, buf_we;
    logic [MAX_CAND-1:0] not_entered, reach_step;
    logic [CNT_W-1:0]    rank_p1, rj_p1, ri_p2, ec_p1;
    logic [PAIR_W-1:0]   tot_nx;
    logic                higher;

    rpet_tally_store u_tally (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (tq),
        .o_rd_data (tv)
    );

    always_comb begin
        if (r_cand_total < CNT_W'(2)) begin
            eff_n = CNT_W'(2);
        end else if (r_cand_total > CNT_W'(MAX_CAND)) begin
            eff_n = CNT_W'(MAX_CAND);
        end else begin
            eff_n = r_cand_total;
        end
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign buf_ra     = (r_state == S_REC_LDA) ? r_ri : r_rj;
    assign buf_rd     = r_buf[buf_ra];
    assign rank_p1    = {1'b0, r_rank} + CNT_W'(1);
    assign rj_p1      = {1'b0, r_rj} + CNT_W'(1);
    assign ri_p2      = {1'b0, r_ri} + CNT_W'(2);
    assign ec_p1      = {1'b0, r_ec} + CNT_W'(1);
    assign buf_we     = in_acc && (i_operation == OP_BALLOT)
                        && ({1'b0, i_candidate_index} < eff_n);

    always_comb begin
        for (int c = 0; c < MAX_CAND; c++) begin
            not_entered[c] = (CNT_W'(c) < eff_n);
            reach_step[c]  = 1'b0;
            for (int u = 0; u < MAX_CAND; u++) begin
                if (r_lock[u][c]) begin
                    not_entered[c] = 1'b0;
                end
                if (r_reach[u] && r_lock[u][c]) begin
                    reach_step[c] = 1'b1;
                end
            end
        end
        higher = 1'b0;
        for (int k = 0; k < MAX_CAND; k++) begin
            if (CAND_W'(k) > r_ec && not_entered[k]) begin
                higher = 1'b1;
            end
        end
    end

    assign tot_nx = r_pair_total + PAIR_W'(tv != r_sa);

    always_comb begin
        n_state      = r_state;
        n_rank       = r_rank;
        n_ri         = r_ri;
        n_rj         = r_rj;
        n_a          = r_a;
        n_sa         = r_sa;
        n_pair_total = r_pair_total;
        n_pi         = r_pi;
        n_pj         = r_pj;
        n_cur        = r_cur;
        n_w          = r_w;
        n_l          = r_l;
        n_ec         = r_ec;
        n_reach      = r_reach;
        n_lock       = r_lock;
        n_out_valid  = r_out_valid && i_out_stall;
        n_kind       = r_kind;
        n_win        = r_win;
        n_last       = r_last;
        tq           = '0;
        pm_we        = 1'b0;
        pm_waddr     = r_pj;
        pm_wdata     = r_cur;
        pm_raddr     = r_pi;

        case (r_state)
            S_IDLE: begin
                if (in_acc && i_operation == OP_CLOSE) begin
                    n_ri         = '0;
                    n_rj         = CAND_W'(1);
                    n_pair_total = '0;
                    n_state      = S_BLD_RD1;
                end else if (in_acc && !buf_we) begin
                    n_rank      = '0;
                    n_out_valid = 1'b1;
                    n_kind      = KIND_ERR;
                    n_win       = '0;
                    n_last      = 1'b1;
                end else if (buf_we) begin
                    if (rank_p1 >= eff_n) begin
                        n_rank  = '0;
                        n_ri    = '0;
                        n_rj    = CAND_W'(1);
                        n_state = S_REC_LDA;
                    end else begin
                        n_rank = CAND_W'(rank_p1);
                    end
                end
            end
            S_REC_LDA: begin
                n_a     = buf_rd;
                n_state = S_REC_RD;
            end
            S_REC_RD: begin
                tq.rd_addr = {r_a, buf_rd};
                n_state    = S_REC_WR;
            end
            S_REC_WR: begin
                tq.wr_en   = 1'b1;
                tq.wr_addr = {r_a, buf_rd};
                tq.wr_data = (tv == '1) ? tv : TALLY_W'(tv + 1'b1);
                if (rj_p1 < eff_n) begin
                    n_rj    = CAND_W'(rj_p1);
                    n_state = S_REC_RD;
                end else if (ri_p2 < eff_n) begin
                    n_ri    = r_ri + 1'b1;
                    n_rj    = CAND_W'(ri_p2);
                    n_state = S_REC_LDA;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BLD_RD1: begin
                tq.rd_addr = {r_ri, r_rj};
                n_state    = S_BLD_RD2;
            end
            S_BLD_RD2: begin
                n_sa       = tv;
                tq.rd_addr = {r_rj, r_ri};
                n_state    = S_BLD_CMP;
            end
            S_BLD_CMP: begin
                // skip ties; the pair keeps its winning tally for the sort
                if (tv != r_sa) begin
                    pm_we          = 1'b1;
                    pm_waddr       = r_pair_total;
                    pm_wdata.win   = (r_sa > tv) ? r_ri : r_rj;
                    pm_wdata.lose  = (r_sa > tv) ? r_rj : r_ri;
                    pm_wdata.score = (r_sa > tv) ? r_sa : tv;
                end
                n_pair_total = tot_nx;
                n_pi         = '0;
                if (rj_p1 < eff_n) begin
                    n_rj    = CAND_W'(rj_p1);
                    n_state = S_BLD_RD1;
                end else if (ri_p2 < eff_n) begin
                    n_ri    = r_ri + 1'b1;
                    n_rj    = CAND_W'(ri_p2);
                    n_state = S_BLD_RD1;
                end else if (tot_nx >= PAIR_W'(2)) begin
                    n_state = S_SRT_LDI;
                end else if (tot_nx != '0) begin
                    n_state = S_LCK_RD;
                end else begin
                    n_ec    = '0;
                    n_state = S_EMIT;
                end
            end
            S_SRT_LDI: begin
                pm_raddr = r_pi;
                n_state  = S_SRT_CAP;
            end
            S_SRT_CAP: begin
                n_cur   = r_pair_rd;
                n_pj    = r_pi + 1'b1;
                n_state = S_SRT_RDJ;
            end
            S_SRT_RDJ: begin
                pm_raddr = r_pj;
                n_state  = S_SRT_CMP;
            end
            S_SRT_CMP: begin
                // swap: the held pair drops to slot j, the larger one is held
                if (r_pair_rd.score > r_cur.score) begin
                    pm_we    = 1'b1;
                    pm_waddr = r_pj;
                    pm_wdata = r_cur;
                    n_cur    = r_pair_rd;
                end
                if (r_pj + 1'b1 < r_pair_total) begin
                    n_pj    = r_pj + 1'b1;
                    n_state = S_SRT_RDJ;
                end else begin
                    n_state = S_SRT_WRI;
                end
            end
            S_SRT_WRI: begin
                pm_we    = 1'b1;
                pm_waddr = r_pi;
                pm_wdata = r_cur;
                if (r_pi + PAIR_W'(2) < r_pair_total) begin
                    n_pi    = r_pi + 1'b1;
                    n_state = S_SRT_LDI;
                end else begin
                    n_pi    = '0;
                    n_state = S_LCK_RD;
                end
            end
            S_LCK_RD: begin
                pm_raddr = r_pi;
                n_state  = S_LCK_CAP;
            end
            S_LCK_CAP: begin
                n_w                      = r_pair_rd.win;
                n_l                      = r_pair_rd.lose;
                n_reach                  = '0;
                n_reach[r_pair_rd.lose]  = 1'b1;
                n_state                  = S_LCK_GROW;
            end
            S_LCK_GROW: begin
                // widen the reach set one hop per cycle until it settles
                n_reach = r_reach | reach_step;
                if ((r_reach | reach_step) == r_reach) begin
                    if (!r_reach[r_w]) begin
                        n_lock[r_w][r_l] = 1'b1;
                    end
                    if (r_pi + 1'b1 < r_pair_total) begin
                        n_pi    = r_pi + 1'b1;
                        n_state = S_LCK_RD;
                    end else begin
                        n_ec    = '0;
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    if (not_entered[r_ec]) begin
                        n_out_valid = 1'b1;
                        n_kind      = KIND_WIN;
                        n_win       = r_ec;
                        n_last      = !higher;
                    end
                    if (ec_p1 >= eff_n) begin
                        tq.clr       = 1'b1;
                        for (int u = 0; u < MAX_CAND; u++) begin
                            n_lock[u] = '0;
                        end
                        n_rank       = '0;
                        n_pair_total = '0;
                        n_reach      = '0;
                        n_state      = S_IDLE;
                    end else begin
                        n_ec = CAND_W'(ec_p1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_rank = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cand_total <= CNT_W'(MAX_CAND);
            r_rank       <= '0;
            r_pair_total <= '0;
            r_reach      <= '0;
            r_out_valid  <= 1'b0;
            for (int u = 0; u < MAX_CAND; u++) begin
                r_lock[u] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_rank       <= n_rank;
            r_pair_total <= n_pair_total;
            r_reach      <= n_reach;
            r_out_valid  <= n_out_valid;
            r_lock       <= n_lock;
            if (i_cfg_we) begin
                r_cand_total <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ri   <= n_ri;
        r_rj   <= n_rj;
        r_a    <= n_a;
        r_sa   <= n_sa;
        r_pi   <= n_pi;
        r_pj   <= n_pj;
        r_cur  <= n_cur;
        r_w    <= n_w;
        r_l    <= n_l;
        r_ec   <= n_ec;
        r_kind <= n_kind;
        r_win  <= n_win;
        r_last <= n_last;
        if (buf_we) begin
            r_buf[r_rank] <= i_candidate_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pm_we) begin
            r_pair_mem[pm_waddr] <= pm_wdata;
        end
        r_pair_rd <= r_pair_mem[pm_raddr];
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_kind;
    assign o_winner_index = r_win;
    assign o_last_result  = r_last;

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input taken while sequencer busy");

    a_pair_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pair_total <= PAIR_W'(PAIR_SLOTS))
        else $error("pair count beyond slot count");

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_ERR) |->
        (o_last_result && o_winner_index == '0))
        else $error("malformed error result");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && n_state == S_IDLE) |=>
        (r_pair_total == '0 && r_lock[0] == '0))
        else $error("close did not clear state");

    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_rank} < eff_n))
        else $error("rank position out of range");

endmodule

>>> tb/sv/ranked_pairs_election_tally_top_tb.sv
// Testbench for the ranked-pairs election tally: directed and random ballots and closes,
// predicted by a tally scoreboard class and checked per result. Depends on rpet_pkg and the RTL.
module ranked_pairs_election_tally_top_tb;
    import rpet_pkg::*;

    localparam int WATCH_LIMIT = 20000;

    typedef struct packed {
        logic                kind;
        logic [CAND_W-1:0]   winner;
        logic                last;
    } t_report;

    class tally_scoreboard;
        bit [TALLY_W-1:0] votes [MAX_CAND][MAX_CAND];
        bit [CAND_W-1:0]  ballot [MAX_CAND];
        int unsigned      rank_pos;
        bit [CNT_W-1:0]   count_reg;
        t_report          pending [$];
        int unsigned      errors;

        function new();
            count_reg = 4'd8;
        endfunction

        function int unsigned active_count();
            int unsigned n;
            n = count_reg;
            if (n < 2) n = 2;
            if (n > MAX_CAND) n = MAX_CAND;
            return n;
        endfunction

        function void write_count(bit [CNT_W-1:0] v);
            count_reg = v;
            rank_pos = 0;
        endfunction

        function void tally_ballot(int unsigned n);
            for (int i = 0; i < n; i++)
                for (int j = i + 1; j < n; j++)
                    if (votes[ballot[i]][ballot[j]] != '1)
                        votes[ballot[i]][ballot[j]]++;
        endfunction

        function void tally_close(int unsigned n);
            bit [CAND_W-1:0] pw [$];
            bit [CAND_W-1:0] pl [$];
            bit              locked [MAX_CAND][MAX_CAND];
            bit [MAX_CAND-1:0] seen;
            bit              grew, entered;
            bit [CAND_W-1:0] t;
            int              first;
            t_report         r;
            for (int i = 0; i < MAX_CAND; i++)
                for (int j = 0; j < MAX_CAND; j++) locked[i][j] = 0;
            for (int i = 0; i < n; i++)
                for (int j = i + 1; j < n; j++) begin
                    if (votes[i][j] == votes[j][i]) continue;
                    pw.push_back(CAND_W'(votes[i][j] > votes[j][i] ? i : j));
                    pl.push_back(CAND_W'(votes[i][j] > votes[j][i] ? j : i));
                end
            for (int i = 0; i + 1 < pw.size(); i++)
                for (int j = i + 1; j < pw.size(); j++)
                    if (votes[pw[j]][pl[j]] > votes[pw[i]][pl[i]]) begin
                        t = pw[i]; pw[i] = pw[j]; pw[j] = t;
                        t = pl[i]; pl[i] = pl[j]; pl[j] = t;
                    end
            for (int p = 0; p < pw.size(); p++) begin
                seen = '0;
                seen[pl[p]] = 1;
                grew = 1;
                while (grew) begin
                    grew = 0;
                    for (int u = 0; u < n; u++)
                        if (seen[u])
                            for (int v = 0; v < n; v++)
                                if (locked[u][v] && !seen[v]) begin
                                    seen[v] = 1;
                                    grew = 1;
                                end
                end
                if (!seen[pw[p]]) locked[pw[p]][pl[p]] = 1;
            end
            first = pending.size();
            for (int i = 0; i < n; i++) begin
                entered = 0;
                for (int j = 0; j < n; j++) if (locked[j][i]) entered = 1;
                if (!entered) begin
                    r.kind = KIND_WIN;
                    r.winner = CAND_W'(i);
                    r.last = 0;
                    pending.push_back(r);
                end
            end
            if (pending.size() > first) pending[pending.size() - 1].last = 1;
            for (int i = 0; i < MAX_CAND; i++)
                for (int j = 0; j < MAX_CAND; j++) votes[i][j] = '0;
            rank_pos = 0;
        endfunction

        function void note_input(logic op, logic [CAND_W-1:0] cand);
            int unsigned n;
            t_report r;
            n = active_count();
            if (op == OP_CLOSE) begin
                tally_close(n);
            end else if (cand >= n) begin
                rank_pos = 0;
                r.kind = KIND_ERR;
                r.winner = '0;
                r.last = 1;
                pending.push_back(r);
            end else begin
                if (rank_pos >= n) rank_pos = 0;
                ballot[rank_pos] = cand;
                rank_pos++;
                if (rank_pos >= n) begin
                    tally_ballot(n);
                    rank_pos = 0;
                end
            end
        endfunction

        function void check_result(t_report got);
            t_report exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result kind=%0d winner=%0d last=%0d", $time,
                         got.kind, got.winner, got.last);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.kind !== exp_r.kind) begin
                $display("%0t: result_kind expected %0d actual %0d", $time, exp_r.kind, got.kind);
                errors++;
            end
            if (got.winner !== exp_r.winner) begin
                $display("%0t: winner_index expected %0d actual %0d", $time,
                         exp_r.winner, got.winner);
                errors++;
            end
            if (got.last !== exp_r.last) begin
                $display("%0t: last_result expected %0d actual %0d", $time, exp_r.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_operation;
    logic [CAND_W-1:0] i_candidate_index;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_result_kind;
    logic [CAND_W-1:0] o_winner_index;
    logic              o_last_result;
    logic              i_cfg_we;
    logic [CNT_W-1:0]  i_cfg_data;

    tally_scoreboard board;
    int unsigned     send_idle_pct;
    int unsigned     recv_stall_pct;
    int unsigned     idle_cycles;
    bit              run_done;

    ranked_pairs_election_tally_top DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_candidate_index (i_candidate_index),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_result_kind     (o_result_kind),
        .o_winner_index    (o_winner_index),
        .o_last_result     (o_last_result),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Check results and count cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                board.check_result('{o_result_kind, o_winner_index, o_last_result});
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall) || run_done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCH_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || recv_stall_pct == 0)
            i_out_stall <= 0;
        else
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Valid stays high on return; the next call or drain() sets it.
    task automatic send_entry(logic op, logic [CAND_W-1:0] cand);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid        <= 1;
        i_operation       <= op;
        i_candidate_index <= cand;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_input(op, cand);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        // a ballot tally update can still be running with nothing expected
        repeat (200) @(negedge i_clk);
    endtask

    task automatic set_count(bit [CNT_W-1:0] v);
        drain();
        i_cfg_we   <= 1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        board.write_count(v);
    endtask

    task automatic send_ballot(int unsigned n);
        int unsigned perm [$];
        int unsigned k, t;
        for (int i = 0; i < n; i++) perm.push_back(i);
        for (int i = n - 1; i > 0; i--) begin
            k = $urandom_range(i);
            t = perm[i]; perm[i] = perm[k]; perm[k] = t;
        end
        // occasional duplicate entry
        if ($urandom_range(9) == 0) perm[$urandom_range(n - 1)] = $urandom_range(n - 1);
        foreach (perm[i]) send_entry(OP_BALLOT, CAND_W'(perm[i]));
    endtask

    task automatic random_phase(int unsigned items);
        int unsigned sent, n, r;
        sent = 0;
        while (sent < items) begin
            n = board.active_count();
            r = $urandom_range(99);
            if (r < 70) begin
                send_ballot(n);
                sent += n;
            end else if (r < 82) begin
                send_entry(OP_CLOSE, CAND_W'($urandom));
                sent++;
            end else begin
                send_entry(OP_BALLOT, CAND_W'($urandom));
                sent++;
            end
        end
        send_entry(OP_CLOSE, CAND_W'($urandom));
    endtask

    initial begin
        board = new();
        run_done = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_operation = OP_BALLOT;
        i_candidate_index = '0;
        i_out_stall = 0;
        i_cfg_we = 0;
        i_cfg_data = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1;

        // directed: empty close, full ballots, error, partial-ballot close
        send_entry(OP_CLOSE, 3'd0);
        for (int i = 0; i < MAX_CAND; i++) send_entry(OP_BALLOT, CAND_W'(i));
        for (int i = MAX_CAND - 1; i >= 0; i--) send_entry(OP_BALLOT, CAND_W'(i));
        send_entry(OP_BALLOT, 3'd7);
        send_entry(OP_CLOSE, 3'd7);
        set_count(4'd2);
        send_entry(OP_BALLOT, 3'd1);
        send_entry(OP_BALLOT, 3'd0);
        send_entry(OP_BALLOT, 3'd2);
        send_entry(OP_BALLOT, 3'd0);
        send_entry(OP_CLOSE, 3'd0);
        set_count(4'd0);
        send_entry(OP_BALLOT, 3'd0);
        send_entry(OP_BALLOT, 3'd1);
        send_entry(OP_CLOSE, 3'd5);
        set_count(4'd15);

        send_idle_pct = 11;
        recv_stall_pct = 60;
        set_count(4'd3);
        random_phase(60);
        send_idle_pct = 60;
        recv_stall_pct = 11;
        set_count(4'd8);
        random_phase(70);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_count(4'd5);
        random_phase(60);
        drain();
        run_done = 1;

        if (board.errors == 0 && board.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

>>> ranked_pairs_election_tally_top.f
rtl/core/rpet_pkg.sv
rtl/core/rpet_tally_store.sv
rtl/core/ranked_pairs_election_tally_top.sv
tb/sv/ranked_pairs_election_tally_top_tb.sv
